/* rtl/interpolated_noise_generator_defines.svh */
// Assertion helpers shared by the RTL.
`ifndef INTERPOLATED_NOISE_GENERATOR_DEFINES_SVH
`define INTERPOLATED_NOISE_GENERATOR_DEFINES_SVH

// Checked only while out of reset.
`define ING_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every edge, reset included.
`define ING_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/ing_pkg.sv */
`default_nettype none

package ing_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int PH_W        = FRAC_BITS + 1;
    localparam int LVL_W       = 11;
    localparam int MAG_W       = LVL_W - 1;
    localparam int SEED_W      = 32;
    localparam int LERP_W      = LVL_W + FRAC_BITS + 1;
    localparam int MUL_W       = (LERP_W > SEED_W) ? LERP_W + 1 : SEED_W + 1;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 16;
    localparam int LCG_STEPS   = 6;
    localparam int LCG_CNT_W   = 3;
    localparam int MAG_DRAW    = 2;  // last generator step of the magnitude draw
    localparam int RAND_LSB    = 16;

    localparam logic [PH_W-1:0]   ONE_Q          = PH_W'(1) << FRAC_BITS;
    localparam logic [PH_W-1:0]   PHASE_STEP_RST = PH_W'(6554);
    localparam logic [PH_W-1:0]   VOLUME_RST     = ONE_Q >> 1;
    localparam logic [SEED_W-1:0] SEED_RST       = '0;
    localparam logic [SEED_W-1:0] LCG_MUL        = 32'd1103515245;
    localparam logic [SEED_W-1:0] LCG_ADD        = 32'd12345;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_STEP  = 2'd0,
        REG_VOLUME_GAIN = 2'd1,
        REG_SEED_START  = 2'd2
    } cfg_reg_t;

endpackage

`default_nettype wire

/* rtl/ing_mul.sv */
`default_nettype none

// Shared signed multiplier, product registered when enabled.
module ing_mul
    import ing_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic signed [MUL_W-1:0]  a,
    input  wire logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0]      p
);

    logic signed [PROD_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

/* rtl/interpolated_noise_generator.sv */
// Channel   | Direction | Payload
// s_axis    | in        | tdata[0] tick, [7:1] zero
// m_axis    | out       | tdata[10:0] sample (two's complement), [15:11] zero
// cfg       | in        | cfg_index register, cfg_data value
//
// A tick that continues the current segment passes S_ADV, S_LERP_MUL,
// S_LERP_ADD, S_VOL_MUL and S_OUT to the result register; one that opens a
// new segment first takes six generator steps (multiply then add) on the
// shared multiplier. A zero tick is consumed with no result.
// aresetn is synchronous, active low; cfg_ready is always high.
// The result register holds while a result is pending and m_axis_tready is low; a new tick is still
// taken, and its result waits in the final state until the register frees.
`default_nettype none
`include "interpolated_noise_generator_defines.svh"

module interpolated_noise_generator
    import ing_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]   s_axis_tdata,   // [0] tick
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [M_TDATA_W-1:0]        m_axis_tdata,   // [10:0] sample
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LCG_MUL,
        S_LCG_ADD,
        S_ADV,
        S_LERP_MUL,
        S_LERP_ADD,
        S_VOL_MUL,
        S_OUT
    } state_t;

    state_t                     state_reg, state_next;
    logic [PH_W-1:0]            phase_step_reg, phase_step_next;
    logic [PH_W-1:0]            volume_reg, volume_next;
    logic [SEED_W-1:0]          seed_reg, seed_next;
    logic                       started_reg, started_next;
    logic signed [LVL_W-1:0]    now_reg, now_next;
    logic signed [LVL_W-1:0]    goal_reg, goal_next;
    logic [PH_W-1:0]            phase_reg, phase_next;
    logic [MAG_W-1:0]           mag_reg, mag_next;
    logic [LCG_CNT_W-1:0]       cnt_reg, cnt_next;
    logic signed [LERP_W-1:0]   lerp_reg, lerp_next;
    logic                       m_valid_reg, m_valid_next;
    logic [LVL_W-1:0]           sample_reg, sample_next;

    logic                       mul_en;
    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic signed [PROD_W-1:0]   prod;

    logic [PH_W-1:0]            step_cl, vol_cl, t_cl;
    logic signed [LVL_W:0]      diff;
    logic [SEED_W-1:0]          lcg_val;
    logic                       out_free, in_acc, new_seg;
    logic [LVL_W-1:0]           mag_ext;

    ing_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    assign step_cl  = (phase_step_reg > ONE_Q) ? ONE_Q : phase_step_reg;
    assign vol_cl   = (volume_reg > ONE_Q) ? ONE_Q : volume_reg;
    assign t_cl     = (phase_reg > ONE_Q) ? ONE_Q : phase_reg;
    assign diff     = {goal_reg[LVL_W-1], goal_reg} - {now_reg[LVL_W-1], now_reg};
    assign lcg_val  = prod[SEED_W-1:0] + LCG_ADD;
    assign out_free = !m_valid_reg || m_axis_tready;
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign new_seg  = !started_reg || (phase_reg >= ONE_Q);
    assign mag_ext  = LVL_W'(mag_reg);

    // operand select for the shared multiplier
    always_comb begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            S_LCG_MUL: begin
                mul_en = 1'b1;
                mul_a  = MUL_W'(seed_reg);
                mul_b  = MUL_W'(LCG_MUL);
            end
            S_LERP_MUL: begin
                mul_en = 1'b1;
                mul_a  = MUL_W'(diff);
                mul_b  = MUL_W'(t_cl);
            end
            S_VOL_MUL: begin
                mul_en = 1'b1;
                mul_a  = MUL_W'(lerp_reg);
                mul_b  = MUL_W'(vol_cl);
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        phase_step_next = phase_step_reg;
        volume_next     = volume_reg;
        seed_next       = seed_reg;
        started_next    = started_reg;
        now_next        = now_reg;
        goal_next       = goal_reg;
        phase_next      = phase_reg;
        mag_next        = mag_reg;
        cnt_next        = cnt_reg;
        lerp_next       = lerp_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        sample_next     = sample_reg;

        if (cfg_valid) begin
            unique case (cfg_index)
                REG_PHASE_STEP:  phase_step_next = cfg_data[PH_W-1:0];
                REG_VOLUME_GAIN: volume_next     = cfg_data[PH_W-1:0];
                REG_SEED_START:  seed_next       = cfg_data[SEED_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_acc && s_axis_tdata[0]) begin
                    cnt_next   = '0;
                    state_next = new_seg ? S_LCG_MUL : S_ADV;
                end
            end
            S_LCG_MUL: begin
                state_next = S_LCG_ADD;
            end
            S_LCG_ADD: begin
                seed_next = lcg_val;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == LCG_CNT_W'(MAG_DRAW)) begin
                    mag_next = lcg_val[RAND_LSB +: MAG_W];
                end
                if (cnt_reg == LCG_CNT_W'(LCG_STEPS - 1)) begin
                    now_next     = goal_reg;
                    goal_next    = lcg_val[RAND_LSB] ? signed'(mag_ext)
                                                     : -signed'(mag_ext);
                    phase_next   = '0;
                    started_next = 1'b1;
                    state_next   = S_ADV;
                end else begin
                    state_next = S_LCG_MUL;
                end
            end
            S_ADV: begin
                phase_next = phase_reg + step_cl;
                state_next = S_LERP_MUL;
            end
            S_LERP_MUL: begin
                state_next = S_LERP_ADD;
            end
            S_LERP_ADD: begin
                // level_now scaled to the phase format plus diff * t
                lerp_next  = {now_reg[LVL_W-1], now_reg, {FRAC_BITS{1'b0}}}
                             + prod[LERP_W-1:0];
                state_next = S_VOL_MUL;
            end
            S_VOL_MUL: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    // upper bits of the product are the floored quotient
                    sample_next  = prod[2*FRAC_BITS +: LVL_W];
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            phase_step_reg <= PHASE_STEP_RST;
            volume_reg     <= VOLUME_RST;
            seed_reg       <= SEED_RST;
            started_reg    <= 1'b0;
            now_reg        <= '0;
            goal_reg       <= '0;
            phase_reg      <= '0;
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_step_reg <= phase_step_next;
            volume_reg     <= volume_next;
            seed_reg       <= seed_next;
            started_reg    <= started_next;
            now_reg        <= now_next;
            goal_reg       <= goal_next;
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            m_valid_reg    <= m_valid_next;
        end
        mag_reg    <= mag_next;
        lerp_reg   <= lerp_next;
        sample_reg <= sample_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(sample_reg);
    assign cfg_ready     = 1'b1;

    `ING_ASSERT(a_valid_from_out, aclk, aresetn,
        $rose(m_axis_tvalid) |-> $past(state_reg == S_OUT),
        "result raised outside final state")
    `ING_ASSERT(a_goal_range, aclk, aresetn,
        goal_reg != signed'(LVL_W'(1) << (LVL_W - 1)),
        "goal level out of range")
    `ING_ASSERT(a_lcg_count, aclk, aresetn,
        (state_reg == S_LCG_MUL || state_reg == S_LCG_ADD) |-> cnt_reg < LCG_CNT_W'(LCG_STEPS),
        "generator step count overrun")
    `ING_ASSERT(a_new_seg, aclk, aresetn,
        (in_acc && s_axis_tdata[0] && new_seg) |=> state_reg == S_LCG_MUL,
        "new segment not started")
    `ING_ASSERT_ALWAYS(a_reset_idle, aclk,
        $past(!aresetn) |-> (state_reg == S_IDLE && !m_axis_tvalid),
        "not idle after reset")

endmodule

`default_nettype wire
